/* hw/rtl/minv_pkg.sv */
// Shared types for the modular inverse core.
// Holds the sequencer state encoding and the divider status bundle.
// No dependencies.
package minv_pkg;

  // One-hot sequencer states of the top level.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_STEP = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } minv_state_t;

  // Status of the shared divide unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } minv_div_stat_t;

endpackage

/* hw/rtl/modular_inverse_extended_euclid_core.sv */
// Top level of the modular inverse core: sequencer and operand registers.
// Depends on minv_pkg and instantiates minv_div.
//
// Computes the inverse of in_value modulo in_modulus with the extended Euclidean
// algorithm and returns it on the out_ channel, normalized into 0 .. modulus-1.
// The value is first reduced modulo the modulus. If value and modulus are not
// coprime, the normalized Bezout coefficient is returned without any flag; a value
// of zero or a modulus of one gives 0, and so does a modulus of zero. One beat in
// gives exactly one beat out. All arithmetic runs through a single restoring
// divide unit that retires one quotient bit per cycle and, in the same cycle,
// accumulates the quotient times the current coefficient by shift and add. Each
// division loads its operands, then runs one bit step per dividend bit. An item
// needs one division for the initial reduction, one per Euclid step (the first
// step has a zero quotient), and one for the final reduction; the worst case is
// about 90 Euclid steps for 63-bit operands. in_ready is high only while the
// sequencer is idle. The result sits in an output register, so a new beat can be
// accepted while the previous result still waits for out_ready.
module modular_inverse_extended_euclid_core #(
  parameter int DATA_WIDTH = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic [DATA_WIDTH-1:0] in_modulus,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_inverse
);

  // Coefficients are kept in two's complement one bit wider than the data, which
  // holds any coefficient since its magnitude never exceeds the modulus.
  localparam int CW = DATA_WIDTH + 1;

  minv_pkg::minv_state_t    state_r, state_nxt;
  minv_pkg::minv_div_stat_t div_stat;

  logic [DATA_WIDTH-1:0] mod_r, mod_nxt;
  logic [DATA_WIDTH-1:0] rc_r, rc_nxt;
  logic [CW-1:0]         cp_r, cp_nxt;
  logic [CW-1:0]         cc_r, cc_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_inv_r, out_inv_nxt;

  logic                  div_start;
  logic [CW-1:0]         div_dvd;
  logic [DATA_WIDTH-1:0] div_dsr;
  logic [CW-1:0]         div_mulc;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [CW-1:0]         div_prod;

  logic [CW-1:0]         c_new;
  logic [CW-1:0]         c_mag;

  minv_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .mulc     (div_mulc),
    .status   (div_stat),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  assign in_ready    = (state_r == minv_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_inverse = out_inv_r;

  // Next coefficient of a Euclid step, and the magnitude of the coefficient that
  // ends the loop (the current one, which becomes the previous one).
  assign c_new = cp_r - div_prod;
  assign c_mag = cc_r[CW-1] ? (~cc_r + CW'(1)) : cc_r;

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    rc_nxt        = rc_r;
    cp_nxt        = cp_r;
    cc_nxt        = cc_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_inv_nxt   = out_inv_r;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dsr       = '0;
    div_mulc      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      minv_pkg::S_IDLE: begin
        if (in_valid) begin
          mod_nxt = in_modulus;
          if (in_modulus == '0) begin
            res_nxt   = '0;
            state_nxt = minv_pkg::S_OUT;
          end else begin
            // Reduce the value modulo the modulus first.
            div_start = 1'b1;
            div_dvd   = {1'b0, in_value};
            div_dsr   = in_modulus;
            state_nxt = minv_pkg::S_RED;
          end
        end
      end
      minv_pkg::S_RED: begin
        if (div_stat.done) begin
          // Remainder pair starts as (value mod m, m), coefficients as (1, 0).
          rc_nxt    = mod_r;
          cp_nxt    = CW'(1);
          cc_nxt    = '0;
          div_start = 1'b1;
          div_dvd   = {1'b0, div_rem};
          div_dsr   = mod_r;
          div_mulc  = '0;
          state_nxt = minv_pkg::S_STEP;
        end
      end
      minv_pkg::S_STEP: begin
        if (div_stat.done) begin
          rc_nxt = div_rem;
          cp_nxt = cc_r;
          cc_nxt = c_new;
          if (div_rem == '0) begin
            // Loop ends; reduce the surviving coefficient's magnitude by the modulus.
            neg_nxt   = cc_r[CW-1];
            div_start = 1'b1;
            div_dvd   = c_mag;
            div_dsr   = mod_r;
            div_mulc  = '0;
            state_nxt = minv_pkg::S_FIN;
          end else begin
            // The next quotient multiplies the coefficient just produced.
            div_start = 1'b1;
            div_dvd   = {1'b0, rc_r};
            div_dsr   = div_rem;
            div_mulc  = c_new;
          end
        end
      end
      minv_pkg::S_FIN: begin
        if (div_stat.done) begin
          if (neg_r && (div_rem != '0)) begin
            res_nxt = mod_r - div_rem;
          end else if (neg_r) begin
            res_nxt = '0;
          end else begin
            res_nxt = div_rem;
          end
          state_nxt = minv_pkg::S_OUT;
        end
      end
      minv_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = res_r;
          state_nxt     = minv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = minv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= minv_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mod_r     <= mod_nxt;
    rc_r      <= rc_nxt;
    cp_r      <= cp_nxt;
    cc_r      <= cc_nxt;
    neg_r     <= neg_nxt;
    res_r     <= res_nxt;
    out_inv_r <= out_inv_nxt;
  end

  a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == minv_pkg::S_RED) || (state_r == minv_pkg::S_STEP) ||
                      (state_r == minv_pkg::S_FIN))
    else $error("divider finished outside a working state");

  a_step_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == minv_pkg::S_STEP) |-> (rc_r != '0))
    else $error("Euclid step running with a zero divisor");

  a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == minv_pkg::S_RED) || (state_r == minv_pkg::S_STEP) ||
     (state_r == minv_pkg::S_FIN)) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waiting on an idle divider");

endmodule

/* hw/rtl/minv_div.sv */
// Shared restoring divide unit with a fused shift-and-add multiply of the quotient.
// Depends on minv_pkg for the status bundle.
module minv_div #(
  parameter int DATA_WIDTH = 63
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [DATA_WIDTH:0]             dividend,
  input  logic [DATA_WIDTH-1:0]           divisor,
  input  logic [DATA_WIDTH:0]             mulc,
  output minv_pkg::minv_div_stat_t        status,
  output logic [DATA_WIDTH-1:0]           rem,
  output logic [DATA_WIDTH:0]             prod
);

  localparam int CW   = DATA_WIDTH + 1;
  localparam int CNTW = $clog2(CW + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]         dvd_r, dvd_nxt;
  logic [DATA_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]         mulc_r, mulc_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [CW-1:0]         prod_r, prod_nxt;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // One quotient bit per cycle while busy; the partial remainder stays below the divisor.
  assign trial = {rem_r, dvd_r[CW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    mulc_nxt = mulc_r;
    rem_nxt  = rem_r;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(CW);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      mulc_nxt = mulc;
      rem_nxt  = '0;
      prod_nxt = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[CW-2:0], 1'b0};
      rem_nxt  = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      // Product of the quotient and the multiplicand, built MSB first.
      prod_nxt = {prod_r[CW-2:0], 1'b0} + (ge ? mulc_r : '0);
      cnt_nxt  = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    mulc_r <= mulc_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign rem         = rem_r;
  assign prod        = prod_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider did not go busy after start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a preceding run");

endmodule

/* test/testbench.sv */
// Testbench for modular_inverse_extended_euclid_core: directed table plus random beats.
// Depends only on the core RTL (and the minv_pkg it pulls in); self-checking, no files.
// Results are checked against known table answers or an extended-Euclid predictor kept here.
module testbench;

  localparam int W = 63;
  localparam logic [W-1:0] MAXV = {W{1'b1}};
  // Consecutive Fibonacci numbers near the top of the range: the longest Euclid chain.
  localparam logic [W-1:0] FIB91 = 63'd4660046610375530309;
  localparam logic [W-1:0] FIB92 = 63'd7540113804746346429;
  localparam logic [W-1:0] MERSENNE61 = 63'd2305843009213693951;
  localparam logic [W-1:0] POW2_62 = 63'h4000_0000_0000_0000;
  localparam logic [W-1:0] ALT_5 = 63'h5555_5555_5555_5555;
  localparam logic [W-1:0] ALT_A = 63'h2AAA_AAAA_AAAA_AAAA;

  localparam int RANDOM_ITEMS = 80;
  localparam int IDLE_PCT = 28;
  // The receiver holds off this long once, so the output register fills and in_ready drops.
  localparam int HOLD_CYCLES = 4000;
  // The limit covers the worst item, plus the hold on top of it when the output stalls.
  localparam int QUIET_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 7000;

  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic         known;
    logic [W-1:0] inverse;
  } inv_case_t;

  localparam int NUM_DIRECTED = 21;

  // Rows with known set carry the answer that can be seen directly; the rest use the predictor.
  inv_case_t directed_cases [0:NUM_DIRECTED-1] = '{
    '{63'd0,     63'd7,      1'b1, 63'd0},        // zero value
    '{63'd5,     63'd1,      1'b1, 63'd0},        // modulus one
    '{63'd5,     63'd0,      1'b1, 63'd0},        // modulus zero
    '{63'd0,     63'd0,      1'b1, 63'd0},
    '{63'd14,    63'd7,      1'b1, 63'd0},        // value a multiple of the modulus
    '{63'd1,     MAXV,       1'b1, 63'd1},
    '{MAXV,      MAXV,       1'b1, 63'd0},
    '{MAXV - 1,  MAXV,       1'b1, MAXV - 1},     // minus one is its own inverse
    '{MAXV,      63'd2,      1'b1, 63'd1},
    '{63'd3,     63'd7,      1'b1, 63'd5},
    '{63'd4,     63'd6,      1'b0, 63'd0},        // not coprime
    '{FIB91,     FIB92,      1'b0, 63'd0},
    '{FIB92,     FIB91,      1'b0, 63'd0},
    '{ALT_5,     MERSENNE61, 1'b0, 63'd0},
    '{MAXV,      63'd1000003, 1'b0, 63'd0},
    '{63'd2,     POW2_62,    1'b0, 63'd0},        // not coprime, power of two
    '{63'd3,     POW2_62,    1'b0, 63'd0},
    '{63'd1,     63'd1,      1'b1, 63'd0},
    '{ALT_A,     ALT_5,      1'b0, 63'd0},
    '{63'd1,     63'd2,      1'b1, 63'd1},
    '{MAXV,      63'd1,      1'b1, 63'd0}
  };

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] in_value;
  logic [W-1:0] in_modulus;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_inverse;

  logic [W-1:0] expected_inverse_q [$];
  logic [W-1:0] want_inverse;
  int unsigned  beats_sent;
  int unsigned  results_checked;
  int unsigned  wide_beats;
  int unsigned  inverse_mismatches;
  int unsigned  quiet_cycles;
  bit           hold_done;

  modular_inverse_extended_euclid_core #(
    .DATA_WIDTH(W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_modulus (in_modulus),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_inverse(out_inverse)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Extended Euclid with the value's coefficient held in 64-bit two's complement.
  // The coefficient never exceeds the modulus in magnitude, so nothing overflows.
  function automatic logic [W-1:0] ext_euclid_inverse(input logic [W-1:0] v,
                                                      input logic [W-1:0] m);
    logic [63:0] mod64;
    logic [63:0] r_old;
    logic [63:0] r_now;
    logic [63:0] c_old;
    logic [63:0] c_now;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] c_next;
    logic [63:0] mag;
    logic [63:0] red;
    mod64 = {1'b0, m};
    if (mod64 == 64'd0) begin
      return '0;
    end
    r_old = {1'b0, v} % mod64;
    r_now = mod64;
    c_old = 64'd1;
    c_now = 64'd0;
    while (r_now != 64'd0) begin
      quo = r_old / r_now;
      rem = r_old - quo * r_now;
      c_next = c_old - quo * c_now;
      r_old = r_now;
      r_now = rem;
      c_old = c_now;
      c_now = c_next;
    end
    if (c_old[63]) begin
      // Negative coefficient: fold its magnitude back into 0 .. modulus-1.
      mag = ~c_old + 64'd1;
      red = mag % mod64;
      return (red == 64'd0) ? '0 : W'(mod64 - red);
    end
    return W'(c_old % mod64);
  endfunction

  function automatic logic [W-1:0] rand_bits(input int unsigned nbits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (nbits >= W) begin
      return raw[W-1:0];
    end
    return raw[W-1:0] & ((63'd1 << nbits) - 63'd1);
  endfunction

  // A power of a small prime, as the block sees in real use.
  function automatic logic [W-1:0] prime_power();
    int unsigned primes [6] = '{2, 3, 5, 7, 11, 13};
    int unsigned base;
    int unsigned expo;
    logic [63:0] acc;
    base = primes[$urandom_range(0, 5)];
    expo = $urandom_range(1, 62);
    acc = 64'(base);
    while (expo > 1 && acc <= (64'h7FFF_FFFF_FFFF_FFFF / 64'(base))) begin
      acc = acc * 64'(base);
      expo--;
    end
    return acc[W-1:0];
  endfunction

  // The sender never idles for a run of beats in the middle of the random part.
  function automatic bit sender_calm();
    return beats_sent >= 45 && beats_sent < 70;
  endfunction

  // Offer one beat, idling at random first, and queue its expected inverse once accepted.
  // Called and returning at a falling edge; valid and payload hold until the handshake.
  task automatic send_beat(input logic [W-1:0] v, input logic [W-1:0] m,
                           input logic [W-1:0] inv);
    while (!sender_calm() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_modulus <= m;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_inverse_q.push_back(inv);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stimulus: reset, the directed table, then random beats of mixed sizes.
  initial begin : stimulus
    logic [W-1:0] v;
    logic [W-1:0] m;
    logic [63:0]  g;
    int unsigned  kind;
    int unsigned  nb;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_modulus = '0;
    beats_sent = 0;
    wide_beats = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_beat(directed_cases[i].value, directed_cases[i].modulus,
                directed_cases[i].known ? directed_cases[i].inverse :
                ext_euclid_inverse(directed_cases[i].value, directed_cases[i].modulus));
    end

    // Most beats use narrow moduli so the run stays short; about a fifth use full width.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        nb = $urandom_range(2, 24);
        m = rand_bits(nb);
        v = rand_bits($urandom_range(1, W));
      end else if (kind < 75) begin
        m = rand_bits(W);
        v = rand_bits(W);
        wide_beats++;
      end else if (kind < 88) begin
        m = prime_power();
        v = rand_bits($urandom_range(1, W));
      end else begin
        // Value and modulus share a factor, so the answer is not a true inverse.
        g = 64'($urandom_range(2, 4000));
        m = W'(g * (64'(rand_bits($urandom_range(1, 40))) + 64'd1));
        v = W'(g * 64'(rand_bits($urandom_range(1, 40))));
      end
      if (m == '0) begin
        m = 63'd1;
      end
      send_beat(v, m, ext_euclid_inverse(v, m));
    end
    in_valid <= 1'b0;

    while (expected_inverse_q.size() != 0) @(posedge clk);
    // Let any stray beat show up before closing the books.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats (%0d directed, %0d random at full width); checked %0d results.",
             beats_sent, NUM_DIRECTED, wide_beats, results_checked);
    $display("Random moduli covered narrow, full-width, prime-power and shared-factor cases.");
    if (inverse_mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Receiver: random ready, one long hold-off after a few dozen results, and a calm stretch.
  initial begin : receiver
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && results_checked >= 30) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= (results_checked >= 60 && results_checked < 85) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Result checker: every output beat is matched against the oldest expectation.
  initial begin
    results_checked = 0;
    inverse_mismatches = 0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_checked++;
      if (expected_inverse_q.size() == 0) begin
        $error("out_inverse: unexpected beat, expected none, got %0d", out_inverse);
        inverse_mismatches++;
      end else begin
        want_inverse = expected_inverse_q.pop_front();
        if (out_inverse !== want_inverse) begin
          $error("out_inverse mismatch: expected %0d, got %0d", want_inverse, out_inverse);
          inverse_mismatches++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side ends the run.
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a handshake.", quiet_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

endmodule

/* modular_inverse_extended_euclid_core.f */
hw/rtl/minv_pkg.sv
hw/rtl/minv_div.sv
hw/rtl/modular_inverse_extended_euclid_core.sv
test/testbench.sv
